// ===== src/deadband_motor_speed_regulator_unit_macros.svh =====
// Assertion macros for the deadband speed regulator checker.
// No dependencies; included by the checker file only.
`ifndef DEADBAND_MOTOR_SPEED_REGULATOR_UNIT_MACROS_SVH
`define DEADBAND_MOTOR_SPEED_REGULATOR_UNIT_MACROS_SVH

// Checked only outside reset.
`define DMSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define DMSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dmsr_pkg.sv =====
// Shared types, constants and the initial duty table of the speed regulator.
// No dependencies.
`timescale 1ns / 1ps

package dmsr_pkg;

  localparam int LONG_WINDOW_DEF    = 25;
  localparam int SHORT_WINDOW_DEF   = 5;
  localparam int CONTROL_PERIOD_DEF = 5;

  localparam int CNT_W  = 8;
  localparam int RPM_W  = 17;
  localparam int DUTY_W = 7;
  localparam int REF_W  = 14;
  localparam int CNT_MAX = 255;

  localparam int DUTY_MAX = 99;
  localparam int DEADBAND = 59;

  localparam int INSTANT_GAIN = 300;
  localparam int SHORT_GAIN   = 60;
  localparam int LONG_GAIN    = 12;

  // reference thresholds for the initial duty
  localparam int THR_90 = 2250;
  localparam int THR_80 = 3960;
  localparam int THR_70 = 4728;
  localparam int THR_60 = 5140;
  localparam int THR_50 = 5430;
  localparam int THR_40 = 5630;
  localparam int THR_30 = 5770;
  localparam int THR_20 = 5880;
  localparam int THR_10 = 5984;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [RPM_W-1:0]  rpm_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [REF_W-1:0]  ref_t;

  // per-beat control from the top level to each ring
  typedef struct packed {
    logic rd_en;   // new beat accepted, fetch oldest entry
    logic wr_en;   // beat leaves compute stage, write back
    cnt_t cnt;     // sample of the beat in the compute stage
  } ring_ctl_t;

  function automatic duty_t init_duty(input ref_t r);
    duty_t d;
    if      (r < THR_90) d = DUTY_W'(90);
    else if (r < THR_80) d = DUTY_W'(80);
    else if (r < THR_70) d = DUTY_W'(70);
    else if (r < THR_60) d = DUTY_W'(60);
    else if (r < THR_50) d = DUTY_W'(50);
    else if (r < THR_40) d = DUTY_W'(40);
    else if (r < THR_30) d = DUTY_W'(30);
    else if (r < THR_20) d = DUTY_W'(20);
    else if (r < THR_10) d = DUTY_W'(10);
    else                 d = DUTY_W'(0);
    return d;
  endfunction

endpackage

// ===== src/deadband_motor_speed_regulator_unit.sv =====
// Top level of the deadband speed regulator with moving averages.
// Depends on dmsr_pkg and dmsr_ring.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (in_valid/in_ready, pulse_count): one beat per 100 ms tick,
//    carrying the tachometer pulse count of that tick.
//  - Output channel (out_valid/out_ready): one result beat per input beat, in
//    order: instant_rpm, short_avg_rpm, long_avg_rpm, duty_out.
//  - Config channel (cfg_valid/cfg_ready, reference_rpm): sets the target speed
//    and reloads the duty from the threshold table. Write only while idle.
//  - A beat passes the compute stage, then the output register. Throughput: one
//    beat per cycle unless the receiver stalls; the rings have one read and one
//    write port each, and a beat reads at accept and writes back on leaving it.
//  - Every CONTROL_PERIOD-th beat runs the bang-bang step on the short sum
//    as it stood before that beat's sample.
//  - Reset (rst, synchronous): rings read as zero, sums, positions and tick
//    counter clear, reference 0, duty 90. No clearing pass.
//  - Receiver stall: the output register holds; one more beat waits in the
//    compute stage, then in_ready drops until the output is taken.
module deadband_motor_speed_regulator_unit #(
  parameter int LONG_WINDOW    = dmsr_pkg::LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW   = dmsr_pkg::SHORT_WINDOW_DEF,
  parameter int CONTROL_PERIOD = dmsr_pkg::CONTROL_PERIOD_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  dmsr_pkg::ref_t reference_rpm,
  input  logic           in_valid,
  output logic           in_ready,
  input  dmsr_pkg::cnt_t pulse_count,
  output logic           out_valid,
  input  logic           out_ready,
  output dmsr_pkg::rpm_t instant_rpm,
  output dmsr_pkg::rpm_t short_avg_rpm,
  output dmsr_pkg::rpm_t long_avg_rpm,
  output dmsr_pkg::duty_t duty_out
);
  import dmsr_pkg::*;

  localparam int LSUM_W = $clog2(LONG_WINDOW * CNT_MAX + 1);
  localparam int SSUM_W = $clog2(SHORT_WINDOW * CNT_MAX + 1);
  localparam int SPROD_W = SSUM_W + 6;                   // times 60
  localparam int LPROD_W = LSUM_W + 4;                   // times 12
  localparam int ERR_W   = ((SPROD_W > REF_W) ? SPROD_W : REF_W) + 1;
  localparam int TICK_W  = (CONTROL_PERIOD > 1) ? $clog2(CONTROL_PERIOD) : 1;

  // pipeline control
  logic  s1_valid;
  cnt_t  s1_cnt;
  logic  advance;
  logic  accept;
  ring_ctl_t ring_ctl;

  // state registers
  ref_t              reference;
  duty_t             duty;
  duty_t             duty_next;
  logic [TICK_W-1:0] tick;
  logic              fire;

  // sums from the rings
  logic [SSUM_W-1:0] short_sum;
  logic [SSUM_W-1:0] short_sum_next;
  logic [LSUM_W-1:0] long_sum;
  logic [LSUM_W-1:0] long_sum_next;

  logic [SPROD_W-1:0] short_prod_pre;
  logic [ERR_W-1:0]   prod_ext;
  logic [ERR_W-1:0]   ref_ext;
  logic               too_fast;
  logic               too_slow;

  assign cfg_ready = 1'b1;

  // compute stage moves on when the output register is free or being drained
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  assign ring_ctl.rd_en = accept;
  assign ring_ctl.wr_en = advance;
  assign ring_ctl.cnt   = s1_cnt;

  dmsr_ring #(.DEPTH(SHORT_WINDOW), .SUM_W(SSUM_W)) u_short_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .sum      (short_sum),
    .sum_next (short_sum_next)
  );

  dmsr_ring #(.DEPTH(LONG_WINDOW), .SUM_W(LSUM_W)) u_long_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .sum      (long_sum),
    .sum_next (long_sum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cnt <= pulse_count;
    end
  end

  // control step: error = reference - 60 * short_sum (sum before this sample)
  assign short_prod_pre = SPROD_W'(short_sum) * SPROD_W'(SHORT_GAIN);
  assign prod_ext = ERR_W'(short_prod_pre);
  assign ref_ext  = ERR_W'(reference);
  assign too_fast = prod_ext > ref_ext + ERR_W'(DEADBAND);   // error below -59
  assign too_slow = ref_ext > prod_ext + ERR_W'(DEADBAND);   // error above 59
  assign fire     = (tick == TICK_W'(CONTROL_PERIOD - 1));

  always_comb begin
    duty_next = duty;
    if (fire) begin
      if (too_fast) begin
        if (duty < DUTY_W'(DUTY_MAX)) duty_next = duty + 1'b1;
      end else if (too_slow) begin
        if (duty != '0) duty_next = duty - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference <= '0;
      duty      <= init_duty('0);
      tick      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      reference <= reference_rpm;
      duty      <= init_duty(reference_rpm);
    end else if (advance) begin
      duty <= duty_next;
      tick <= fire ? '0 : tick + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      instant_rpm   <= RPM_W'(RPM_W'(s1_cnt) * RPM_W'(INSTANT_GAIN));
      short_avg_rpm <= RPM_W'(SPROD_W'(short_sum_next) * SPROD_W'(SHORT_GAIN));
      long_avg_rpm  <= RPM_W'(LPROD_W'(long_sum_next) * LPROD_W'(LONG_GAIN));
      duty_out      <= duty_next;
    end
  end

endmodule

// ===== src/dmsr_ring.sv =====
// Sample ring in a synchronous memory with its running sum.
// Depends on dmsr_pkg.
`timescale 1ns / 1ps

module dmsr_ring #(
  parameter int DEPTH = dmsr_pkg::SHORT_WINDOW_DEF,
  parameter int SUM_W = $clog2(DEPTH * dmsr_pkg::CNT_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  dmsr_pkg::ring_ctl_t ctl,
  output logic [SUM_W-1:0]  sum,
  output logic [SUM_W-1:0]  sum_next
);
  import dmsr_pkg::*;

  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cnt_t             mem [DEPTH];
  cnt_t             rd_data;
  logic             rd_full;
  logic [POS_W-1:0] rd_pos;
  logic [POS_W-1:0] wr_pos;
  logic             full;
  cnt_t             oldest;

  // memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_pos] <= ctl.cnt;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_pos];
      rd_full <= full;
      wr_pos  <= rd_pos;
    end
  end

  // entries are filled in order, so one flag marks the ring as filled
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos <= '0;
      full   <= 1'b0;
      sum    <= '0;
    end else begin
      if (ctl.rd_en) begin
        if (rd_pos == POS_W'(DEPTH - 1)) begin
          rd_pos <= '0;
          full   <= 1'b1;
        end else begin
          rd_pos <= rd_pos + 1'b1;
        end
      end
      if (ctl.wr_en) begin
        sum <= sum_next;
      end
    end
  end

  assign oldest   = rd_full ? rd_data : '0;
  assign sum_next = sum - SUM_W'(oldest) + SUM_W'(ctl.cnt);

endmodule

// ===== src/dmsr_checker.sv =====
// Port-level checker for the deadband speed regulator, bound to the top level.
// Depends on dmsr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "deadband_motor_speed_regulator_unit_macros.svh"

module dmsr_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input dmsr_pkg::rpm_t instant_rpm,
  input dmsr_pkg::rpm_t short_avg_rpm,
  input dmsr_pkg::rpm_t long_avg_rpm,
  input dmsr_pkg::duty_t duty_out
);
  import dmsr_pkg::*;

  logic                        stall;
  logic                        quad;
  logic [3*RPM_W+DUTY_W-1:0]   beat;

  assign stall = out_valid && !out_ready;
  assign beat  = {instant_rpm, short_avg_rpm, long_avg_rpm, duty_out};
  // every rpm field is a multiple of four
  assign quad  = (instant_rpm[1:0] == 2'b00) && (short_avg_rpm[1:0] == 2'b00) &&
                 (long_avg_rpm[1:0] == 2'b00);

  `DMSR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")
  `DMSR_ASSERT(a_hold, stall |=> out_valid && $stable(beat), "stalled beat changed")
  `DMSR_ASSERT(a_duty_range, out_valid |-> duty_out <= DUTY_W'(DUTY_MAX), "duty above limit")
  `DMSR_ASSERT(a_scaled, out_valid |-> quad, "rpm not a multiple of four")

endmodule

bind deadband_motor_speed_regulator_unit dmsr_checker u_dmsr_checker (.*);
